@@ sv/rtpe_pkg.sv @@
// shared types and constants for the range to ternary prefix expander
`default_nettype none

package rtpe_pkg;

  localparam int unsigned KeyMaxW    = 32;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [KeyMaxW-1:0] range_low;
    logic [KeyMaxW-1:0] range_high;
  } rtpe_req_t;

  typedef struct packed {
    logic [KeyMaxW-1:0] entry_value;
    logic [KeyMaxW-1:0] entry_care_mask;
    logic [KeyMaxW-1:0] entry_end;
    logic               last_entry;
  } rtpe_entry_t;

  typedef struct packed {
    logic [KeyMaxW-1:0] lo;
    logic [KeyMaxW-1:0] hi;
  } rtpe_range_t;

endpackage

`default_nettype wire

@@ sv/rtpe_front.sv @@
// front end: masks the bounds to the key width and puts them in order
`default_nettype none

module rtpe_front import rtpe_pkg::*; #(
  parameter int unsigned KeyWidth = 32
) (
  input  logic        push_i,
  input  rtpe_req_t   req_i,
  input  logic        full_i,
  output logic        wr_en_o,
  output rtpe_range_t range_o
);

  logic [KeyWidth-1:0] a_w;
  logic [KeyWidth-1:0] b_w;
  logic                swap_w;

  assign a_w    = req_i.range_low[KeyWidth-1:0];
  assign b_w    = req_i.range_high[KeyWidth-1:0];
  assign swap_w = (a_w > b_w);

  assign wr_en_o    = push_i && !full_i;
  assign range_o.lo = KeyMaxW'(swap_w ? b_w : a_w);
  assign range_o.hi = KeyMaxW'(swap_w ? a_w : b_w);

endmodule

`default_nettype wire

@@ sv/rtpe_queue.sv @@
// short queue of ordered ranges between the front end and the expander
`default_nettype none

module rtpe_queue import rtpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  rtpe_range_t wr_data_i,
  input  logic        rd_en_i,
  output rtpe_range_t rd_data_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  rtpe_range_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/rtpe_back.sv @@
// expander: walks one range and emits one aligned block per cycle while the result register is free or popped
`default_nettype none

module rtpe_back import rtpe_pkg::*; #(
  parameter int unsigned KeyWidth = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  rtpe_range_t q_data_i,
  output logic        q_rd_o,
  input  logic        pop_i,
  output logic        empty_o,
  output rtpe_entry_t entry_o
);

  localparam int unsigned ExtW       = KeyWidth + 1;
  localparam int unsigned SmearSteps = $clog2(ExtW);
  localparam int unsigned CntW       = $clog2(2 * KeyWidth + 1);

  logic                busy_q, busy_d;
  logic [KeyWidth-1:0] lo_q, lo_d;
  logic [KeyWidth-1:0] hi_q, hi_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  rtpe_entry_t         out_q, out_d;

  logic                load_w;
  logic                step_w;
  logic [ExtW-1:0]     lo_ext_w;
  logic [ExtW-1:0]     size_w;
  logic [ExtW-1:0]     smear_w;
  logic [ExtW-1:0]     size_pow_w;
  logic [ExtW-1:0]     align_w;
  logic [ExtW-1:0]     blk_w;
  logic [ExtW-1:0]     span_ext_w;
  logic [KeyWidth-1:0] span_w;
  logic [KeyWidth-1:0] end_w;
  logic                last_w;

  assign load_w = !busy_q && !q_empty_i;
  assign step_w = busy_q && (!out_valid_q || pop_i);
  assign q_rd_o = load_w;

  // largest power of two not above the remaining key count
  assign lo_ext_w = ExtW'(lo_q);
  assign size_w   = ExtW'(hi_q - lo_q) + ExtW'(1);

  always_comb begin
    smear_w = size_w;
    for (int s = 0; s < SmearSteps; s++) begin
      smear_w = smear_w | (smear_w >> (1 << s));
    end
    size_pow_w = smear_w ^ (smear_w >> 1);
  end

  // alignment of the low bound, zero means aligned to the whole key space
  assign align_w = lo_ext_w & (~lo_ext_w + ExtW'(1));

  always_comb begin
    if (align_w == '0) begin
      blk_w = size_pow_w;
    end else if (align_w < size_pow_w) begin
      blk_w = align_w;
    end else begin
      blk_w = size_pow_w;
    end
  end

  assign span_ext_w = blk_w - ExtW'(1);
  assign span_w     = span_ext_w[KeyWidth-1:0];
  assign end_w      = lo_q + span_w;
  assign last_w     = (end_w == hi_q) || (cnt_q >= CntW'(2 * KeyWidth - 1));

  always_comb begin
    busy_d      = busy_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_w) begin
      busy_d = 1'b1;
      lo_d   = q_data_i.lo[KeyWidth-1:0];
      hi_d   = q_data_i.hi[KeyWidth-1:0];
      cnt_d  = '0;
    end
    if (step_w) begin
      out_valid_d           = 1'b1;
      out_d.entry_value     = KeyMaxW'(lo_q);
      out_d.entry_care_mask = KeyMaxW'(~span_w);
      out_d.entry_end       = KeyMaxW'(end_w);
      out_d.last_entry      = last_w;
      lo_d                  = end_w + KeyWidth'(1);
      cnt_d                 = cnt_q + CntW'(1);
      if (last_w) begin
        busy_d = 1'b0;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    out_q <= out_d;
  end

  assign empty_o = !out_valid_q;
  assign entry_o = out_q;

`ifndef SYNTH
  a_block_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_w |-> (end_w <= hi_q) && (end_w >= lo_q))
    else $error("block passes the high bound");

  a_next_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_w && !last_w |=> busy_q && (lo_q == $past(end_w) + KeyWidth'(1)))
    else $error("next low bound does not follow the block end");

  a_base_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.entry_value & ~out_q.entry_care_mask) == '0))
    else $error("block base not aligned to its mask");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |-> !busy_q && !q_empty_i)
    else $error("range taken while expander busy");
`endif

endmodule

`default_nettype wire

@@ sv/range_to_ternary_prefixes.sv @@
// top level of the range to ternary prefix expander
// Usage:
//   Request side: drive req_i with two bounds and raise push; the request
//   is taken at a clock edge where push is high and full is low. Bounds are
//   cut to KEY_WIDTH bits and swapped when reversed.
//   Result side: while empty is low, entry_o holds the oldest block of the
//   cover; pop high with empty low takes it. Blocks come in ascending order
//   and last_entry marks the final block of each range.
// Timing:
//   A request is written to the request queue, loaded into the expander's
//   range registers, and its first block is then registered onto entry_o.
//   After that the expander gives one block per cycle while pop stays high,
//   and loads the next range from the two-entry request queue after the last block.
//   Requests keep being taken while the queue has room, so a stalled result
//   side fills the queue and then raises full.
// Reset:
//   rst_ni low empties the request queue and the result register; no block
//   is pending afterwards.
`default_nettype none

module range_to_ternary_prefixes import rtpe_pkg::*; #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  rtpe_req_t   req_i,
  output logic        empty,
  input  logic        pop,
  output rtpe_entry_t entry_o
);

  logic        wr_en_w;
  rtpe_range_t wr_range_w;
  logic        q_full_w;
  logic        q_empty_w;
  logic        q_rd_w;
  rtpe_range_t q_data_w;

  rtpe_front #(
    .KeyWidth (KEY_WIDTH)
  ) u_front (
    .push_i  (push),
    .req_i   (req_i),
    .full_i  (q_full_w),
    .wr_en_o (wr_en_w),
    .range_o (wr_range_w)
  );

  rtpe_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en_w),
    .wr_data_i (wr_range_w),
    .rd_en_i   (q_rd_w),
    .rd_data_o (q_data_w),
    .full_o    (q_full_w),
    .empty_o   (q_empty_w)
  );

  rtpe_back #(
    .KeyWidth (KEY_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty_w),
    .q_data_i  (q_data_w),
    .q_rd_o    (q_rd_w),
    .pop_i     (pop),
    .empty_o   (empty),
    .entry_o   (entry_o)
  );

  assign full = q_full_w;

endmodule

`default_nettype wire
